// ----- rtl/cft_pkg.sv -----
// shared types and constants for the connection flow table
package cft_pkg;

   localparam int unsigned TableEntriesDefault = 1024;

   localparam int unsigned ActionW = 2;
   localparam int unsigned AddrW   = 32;
   localparam int unsigned PortW   = 16;
   localparam int unsigned TimeW   = 64;
   localparam int unsigned BytesW  = 32;
   localparam int unsigned CntW64  = 64;
   localparam int unsigned StatusW = 2;
   localparam int unsigned SlotW   = 10;
   localparam int unsigned ActiveW = 11;

   localparam int unsigned KeyW  = AddrW + PortW;
   localparam int unsigned CtrW  = 3 * CntW64;
   // action travels on tuser, the rest on tdata
   localparam int unsigned ReqW  = AddrW + PortW + TimeW + BytesW;
   localparam int unsigned ReqDataW = ((ReqW + 7) / 8) * 8;
   // status travels on tuser, the rest on tdata
   localparam int unsigned RspW  = SlotW + 2 * CntW64 + ActiveW + 3 * CntW64;
   localparam int unsigned RspDataW = ((RspW + 7) / 8) * 8;

   typedef enum logic [ActionW-1:0] {
      ACT_CONNECT = 2'd0,
      ACT_SENT    = 2'd1,
      ACT_RECV    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [StatusW-1:0] {
      STS_MATCHED = 2'd0,
      STS_CREATED = 2'd1,
      STS_FULL    = 2'd2,
      STS_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/connection_flow_table_top.sv -----
// connection flow table: keyed entry memory with byte counters and global totals
//
// Events enter on the req_ stream (action on tuser; destination address and
// port, timestamp, byte count on tdata); each event gives exactly one result
// transfer on the rsp_ stream (status on tuser; slot, entry counters, active
// count, three totals on tdata).
// The valid entries always fill slots 0 to active_entries-1, since entries are
// never released, so a fill count stands in for per-entry valid bits.
// A connect, send or receive event scans the key memory one entry per cycle,
// stopping at a match or after the last active entry; the scan over the
// single-port key memory sets the time an event takes. An event with the
// unused action code skips the scan. One event is in work at a time: req_tready
// is high only while the block is idle.
// The result sits in an output register; a new event is accepted while it
// waits, but the next result is held back until rsp_tready takes the old one.
// Reset clears the fill count, the totals and the output valid flag at once;
// the entry memories need no clearing pass.
module connection_flow_table_top
   import cft_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // action
   input  logic [ActionW-1:0]  req_tuser,
   // dest_addr, dest_port_num, event_time, byte_count
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // status
   output logic [StatusW-1:0]  rsp_tuser,
   // slot_index, entry_sent, entry_received, active_entries,
   // total_connects, total_sent, total_received, zero pad
   output logic [RspDataW-1:0] rsp_tdata
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

   // entry memories: key {addr, port} and counters {start, recv, sent}
   logic [KeyW-1:0] key_mem [TABLE_ENTRIES];
   logic [CtrW-1:0] ctr_mem [TABLE_ENTRIES];

   state_type state_ff, state_in;

   logic [ActionW-1:0] action_ff;
   logic [AddrW-1:0]   addr_ff;
   logic [PortW-1:0]   port_ff;
   logic [TimeW-1:0]   time_ff;
   logic [BytesW-1:0]  bytes_ff;

   logic [CNT_W-1:0]   scan_idx_ff;
   logic               cmp_pend_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               found_ff, found_in;
   logic [KeyW-1:0]    key_rd_ff;
   logic [CtrW-1:0]    ctr_rd_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CntW64-1:0]  conn_tot_ff, conn_tot_in;
   logic [CntW64-1:0]  sent_tot_ff, sent_tot_in;
   logic [CntW64-1:0]  recv_tot_ff, recv_tot_in;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic out_free;
   logic hit;
   logic key_rd_en;
   logic scan_done;
   logic finish;

   logic key_wr_en;
   logic ctr_wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [CtrW-1:0]  ctr_wr_data;

   logic create;
   status_type status;
   logic [CntW64-1:0] e_sent, e_recv, e_start;
   logic [CntW64-1:0] bytes_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   // scan control: compare last read key, issue next read
   assign hit       = cmp_pend_ff && (key_rd_ff == {addr_ff, port_ff});
   assign key_rd_en = (state_ff == ST_SCAN) && !hit && (scan_idx_ff < count_ff);
   assign scan_done = (state_ff == ST_SCAN) && !hit && (scan_idx_ff == count_ff);
   assign finish    = (state_ff == ST_FINISH) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (action_type'(req_tuser) == ACT_NONE) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit || scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      slot_in  = slot_ff;
      found_in = found_ff;
      if (state_ff == ST_IDLE) begin
         found_in = 1'b0;
      end else if (hit) begin
         slot_in  = cmp_idx_ff;
         found_in = 1'b1;
      end

      bytes_ext = CntW64'(bytes_ff);
      e_sent    = ctr_rd_ff[CntW64-1:0];
      e_recv    = ctr_rd_ff[2*CntW64-1:CntW64];
      e_start   = ctr_rd_ff[3*CntW64-1:2*CntW64];

      create      = 1'b0;
      status      = STS_NOMATCH;
      count_in    = count_ff;
      conn_tot_in = conn_tot_ff;
      sent_tot_in = sent_tot_ff;
      recv_tot_in = recv_tot_ff;
      key_wr_en   = 1'b0;
      ctr_wr_en   = 1'b0;
      wr_idx      = slot_ff;
      ctr_wr_data = {e_start, e_recv, e_sent};

      case (action_type'(action_ff))
         ACT_CONNECT: begin
            if (found_ff) begin
               status      = STS_MATCHED;
               conn_tot_in = conn_tot_ff + 1'b1;
            end else if (count_ff != CNT_FULL) begin
               create      = 1'b1;
               status      = STS_CREATED;
               count_in    = count_ff + 1'b1;
               conn_tot_in = conn_tot_ff + 1'b1;
               e_sent      = '0;
               e_recv      = '0;
               wr_idx      = count_ff[IDX_W-1:0];
               key_wr_en   = finish;
               ctr_wr_en   = finish;
               ctr_wr_data = {time_ff, {CntW64{1'b0}}, {CntW64{1'b0}}};
            end else begin
               status = STS_FULL;
            end
         end
         ACT_SENT: begin
            sent_tot_in = sent_tot_ff + bytes_ext;
            if (found_ff) begin
               status      = STS_MATCHED;
               e_sent      = e_sent + bytes_ext;
               ctr_wr_en   = finish;
               ctr_wr_data = {e_start, e_recv, e_sent};
            end
         end
         ACT_RECV: begin
            recv_tot_in = recv_tot_ff + bytes_ext;
            if (found_ff) begin
               status      = STS_MATCHED;
               e_recv      = e_recv + bytes_ext;
               ctr_wr_en   = finish;
               ctr_wr_data = {e_start, e_recv, e_sent};
            end
         end
         default: begin
            status = STS_NOMATCH;
         end
      endcase

      if (!found_ff && !create) begin
         e_sent = '0;
         e_recv = '0;
      end

      rsp_data_in = {
         {(RspDataW - RspW){1'b0}},
         recv_tot_in,
         sent_tot_in,
         conn_tot_in,
         ActiveW'(count_in),
         e_recv,
         e_sent,
         (found_ff || create) ? SlotW'(wr_idx) : {SlotW{1'b0}}
      };
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[wr_idx] <= {addr_ff, port_ff};
      end
      if (key_rd_en) begin
         key_rd_ff <= key_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctr_wr_en) begin
         ctr_mem[wr_idx] <= ctr_wr_data;
      end
      if (hit) begin
         ctr_rd_ff <= ctr_mem[cmp_idx_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_pend_ff  <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         conn_tot_ff  <= '0;
         sent_tot_ff  <= '0;
         recv_tot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cmp_pend_ff <= key_rd_en;
         found_ff    <= found_in;
         if (finish) begin
            count_ff    <= count_in;
            conn_tot_ff <= conn_tot_in;
            sent_tot_ff <= sent_tot_in;
            recv_tot_ff <= recv_tot_in;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff   <= req_tuser;
         addr_ff     <= req_tdata[0 +: AddrW];
         port_ff     <= req_tdata[AddrW +: PortW];
         time_ff     <= req_tdata[AddrW + PortW +: TimeW];
         bytes_ff    <= req_tdata[AddrW + PortW + TimeW +: BytesW];
         scan_idx_ff <= '0;
      end else if (key_rd_en) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      if (key_rd_en) begin
         cmp_idx_ff <= scan_idx_ff[IDX_W-1:0];
      end
      slot_ff <= slot_in;
      if (finish) begin
         rsp_status_ff <= status;
         rsp_data_ff   <= rsp_data_in;
      end
   end

endmodule
